FILE: src/bbd_pkg.sv
// ----------------------------------------------------------------------------
// bbd_pkg: shared constants for the block buffer directory
// Slot count, field widths, command and status codes and sequencer states.
// ----------------------------------------------------------------------------
package bbd_pkg;

    localparam int SLOT_COUNT       = 32;
    localparam int DISK_BLOCK_COUNT = 8192;

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int BLK_W  = 14;
    localparam int TAG_W  = $clog2(DISK_BLOCK_COUNT);
    localparam int AGE_W  = 6;
    localparam int CMD_W  = 2;
    localparam int ST_W   = 2;

    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    // Stream widths, padded to whole bytes.
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DIRTY  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    // Result status.
    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_OOB  = 2'd1;
    localparam logic [ST_W-1:0] ST_MISS = 2'd2;

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

endpackage

FILE: src/block_buffer_directory.sv
// ----------------------------------------------------------------------------
// block_buffer_directory: directory of a fully associative disk block buffer
// Keeps used, dirty, tag and age per slot; allocates with age replacement,
// looks up and marks slots dirty, one slot examined per clock.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Beat contents (lowest bit first)
//  --------+-----------+---------------------------------------------------------
//  s_axis  | in        | command[1:0], block_number[15:2]
//  m_axis  | out       | status[1:0], slot_index[6:2], writeback_valid[7],
//          |           | writeback_block[20:8], zero pad[23:21]
//
//  An allocate, lookup or set-dirty beat is accepted, then a single age/tag
//  compare unit walks all 32 slots in turn, and a commit cycle writes the
//  chosen slot and loads the result register. An out-of-bound block number
//  skips the slot walk and leaves the directory untouched; command 3 is
//  dropped in the accept cycle and gives no result. Reset (aresetn low at a
//  clock edge) frees every slot and clears dirty flags and ages at once, with
//  no clearing pass. The result register lets the next beat be accepted while a
//  result waits; the commit cycle waits only if that register is still full.
//
module block_buffer_directory (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // command[1:0], block_number[15:2]
    input  logic [bbd_pkg::S_DATA_W-1:0] s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // status[1:0], slot_index[6:2], writeback_valid[7], writeback_block[20:8]
    output logic [bbd_pkg::M_DATA_W-1:0] m_axis_tdata
);

    localparam int SW = bbd_pkg::SLOT_W;
    localparam int TW = bbd_pkg::TAG_W;
    localparam int AW = bbd_pkg::AGE_W;

    // Slot storage. Used, dirty and age are reset; tags only matter once used.
    logic [bbd_pkg::SLOT_COUNT-1:0] used_reg;
    logic [bbd_pkg::SLOT_COUNT-1:0] dirty_reg;
    logic [AW-1:0]                  age_reg [bbd_pkg::SLOT_COUNT];
    logic [TW-1:0]                  tag_mem [bbd_pkg::SLOT_COUNT];

    // Sequencer and request registers.
    logic [1:0]               state_reg, state_next;
    logic [SW-1:0]            idx_reg;
    logic [bbd_pkg::CMD_W-1:0] cmd_reg;
    logic [TW-1:0]            blk_reg;
    logic                     oob_reg;

    // Scan trackers: first free slot, oldest slot, first matching slot.
    logic          free_found_reg;
    logic [SW-1:0] free_idx_reg;
    logic [AW-1:0] best_age_reg;
    logic [SW-1:0] best_idx_reg;
    logic          best_dirty_reg;
    logic [TW-1:0] best_tag_reg;
    logic          match_found_reg;
    logic [SW-1:0] match_idx_reg;

    // Result register.
    logic                         m_valid_reg;
    logic [bbd_pkg::M_DATA_W-1:0] m_data_reg;

    logic [bbd_pkg::CMD_W-1:0] s_cmd;
    logic [bbd_pkg::BLK_W-1:0] s_blk;
    logic                      s_fire;
    logic                      s_oob;

    logic          cur_used;
    logic [AW-1:0] cur_age;
    logic [AW-1:0] aged;
    logic [TW-1:0] cur_tag;
    logic          last_slot;
    logic          commit;

    logic [SW-1:0]          res_idx;
    logic [bbd_pkg::ST_W-1:0] res_status;
    logic                   res_wb_valid;
    logic [TW-1:0]          res_wb_block;

    assign s_cmd  = s_axis_tdata[bbd_pkg::CMD_W-1:0];
    assign s_blk  = s_axis_tdata[bbd_pkg::CMD_W +: bbd_pkg::BLK_W];
    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign s_oob  = s_blk >= bbd_pkg::BLK_W'(bbd_pkg::DISK_BLOCK_COUNT);

    assign s_axis_tready = (state_reg == bbd_pkg::S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // The shared slot unit: one slot's fields, its aged value and tag compare.
    assign cur_used  = used_reg[idx_reg];
    assign cur_age   = age_reg[idx_reg];
    assign cur_tag   = tag_mem[idx_reg];
    assign aged      = (cur_used && cur_age != bbd_pkg::AGE_MAX) ? cur_age + 1'b1 : cur_age;
    assign last_slot = (idx_reg == SW'(bbd_pkg::SLOT_COUNT - 1));

    // The commit cycle runs once the result register can take the result.
    assign commit = (state_reg == bbd_pkg::S_DONE) && (!m_valid_reg || m_axis_tready);

    // Result selection at commit. A free slot wins over eviction of the oldest.
    always_comb begin
        res_status   = bbd_pkg::ST_OK;
        res_idx      = '0;
        res_wb_valid = 1'b0;
        res_wb_block = '0;
        if (oob_reg) begin
            res_status = bbd_pkg::ST_OOB;
        end else if (cmd_reg == bbd_pkg::CMD_ALLOC) begin
            if (free_found_reg) begin
                res_idx = free_idx_reg;
            end else begin
                res_idx      = best_idx_reg;
                res_wb_valid = best_dirty_reg;
                res_wb_block = best_dirty_reg ? best_tag_reg : '0;
            end
        end else if (match_found_reg) begin
            res_idx = match_idx_reg;
        end else begin
            res_status = bbd_pkg::ST_MISS;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bbd_pkg::S_IDLE: begin
                if (s_fire && s_cmd != bbd_pkg::CMD_NONE) begin
                    state_next = s_oob ? bbd_pkg::S_DONE : bbd_pkg::S_SCAN;
                end
            end
            bbd_pkg::S_SCAN: begin
                if (last_slot) begin
                    state_next = bbd_pkg::S_DONE;
                end
            end
            bbd_pkg::S_DONE: begin
                if (commit) begin
                    state_next = bbd_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bbd_pkg::S_IDLE;
            end
        endcase
    end

    // Control state, flags and ages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bbd_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
            used_reg    <= '0;
            dirty_reg   <= '0;
            for (int i = 0; i < bbd_pkg::SLOT_COUNT; i++) begin
                age_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            // Aging happens as the allocate scan passes each slot.
            if (state_reg == bbd_pkg::S_SCAN && cmd_reg == bbd_pkg::CMD_ALLOC) begin
                age_reg[idx_reg] <= aged;
            end
            if (commit && !oob_reg) begin
                if (cmd_reg == bbd_pkg::CMD_ALLOC) begin
                    used_reg[res_idx]  <= 1'b1;
                    dirty_reg[res_idx] <= 1'b0;
                    age_reg[res_idx]   <= '0;
                end else if (cmd_reg == bbd_pkg::CMD_DIRTY && match_found_reg) begin
                    dirty_reg[match_idx_reg] <= 1'b1;
                end
            end
        end
    end

    // Tag store: written only when a slot is allocated.
    always_ff @(posedge aclk) begin
        if (commit && !oob_reg && cmd_reg == bbd_pkg::CMD_ALLOC) begin
            tag_mem[res_idx] <= blk_reg;
        end
    end

    // Request capture, scan counter and trackers.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg         <= s_cmd;
            blk_reg         <= s_blk[TW-1:0];
            oob_reg         <= s_oob;
            idx_reg         <= '0;
            free_found_reg  <= 1'b0;
            match_found_reg <= 1'b0;
        end else if (state_reg == bbd_pkg::S_SCAN) begin
            idx_reg <= idx_reg + 1'b1;
            if (!cur_used && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= idx_reg;
            end
            // Strictly greater keeps the lowest index on a tie.
            if (idx_reg == '0 || aged > best_age_reg) begin
                best_age_reg   <= aged;
                best_idx_reg   <= idx_reg;
                best_dirty_reg <= dirty_reg[idx_reg];
                best_tag_reg   <= cur_tag;
            end
            if (cur_used && cur_tag == blk_reg && !match_found_reg) begin
                match_found_reg <= 1'b1;
                match_idx_reg   <= idx_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_data_reg <= {3'b000, res_wb_block, res_wb_valid, res_idx, res_status};
        end
    end

endmodule

FILE: src/bbd_checker.sv
// ----------------------------------------------------------------------------
// bbd_checker: port-level checks for the block buffer directory
// Watches both stream channels and the result fields over time.
// ----------------------------------------------------------------------------
module bbd_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic [bbd_pkg::S_DATA_W-1:0] s_axis_tdata,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [bbd_pkg::M_DATA_W-1:0] m_axis_tdata
);

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

    // A real command keeps the input closed on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] != bbd_pkg::CMD_NONE
        |=> !s_axis_tready)
    else $error("input ready while a command is in progress");

    // A failed command reports slot zero and no write-back.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[1:0] != bbd_pkg::ST_OK
        |-> m_axis_tdata[7:2] == '0)
    else $error("failed command carries a slot or write-back");

    // Write-back block is zero unless a write-back is flagged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[7] |-> m_axis_tdata[23:8] == '0)
    else $error("write-back block without write-back");

endmodule

bind block_buffer_directory bbd_checker u_bbd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the block buffer directory
// Streams allocate, lookup and set-dirty beats into the directory, predicts
// each reply with a behavioral copy of the slot table and compares every
// result beat field by field, under several sender and receiver idle mixes.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // A directory request as it travels on the input stream.
    typedef struct packed {
        logic [bbd_pkg::CMD_W-1:0] command;
        logic [bbd_pkg::BLK_W-1:0] block_number;
    } dir_request_t;

    // A directory reply as it travels on the output stream.
    typedef struct packed {
        logic [bbd_pkg::ST_W-1:0]   status;
        logic [bbd_pkg::SLOT_W-1:0] slot_index;
        logic                       writeback_valid;
        logic [bbd_pkg::TAG_W-1:0]  writeback_block;
    } dir_reply_t;

    localparam int POOL_SIZE    = 48;      // more blocks than slots, so evictions occur
    localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
    localparam int TAIL_CYCLES  = 80;      // quiet tail after the last phase
    localparam int CYCLE_LIMIT  = 400000;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    // command[1:0], block_number[15:2]
    logic [bbd_pkg::S_DATA_W-1:0]  s_axis_tdata = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    // status[1:0], slot_index[6:2], writeback_valid[7], writeback_block[20:8]
    logic [bbd_pkg::M_DATA_W-1:0]  m_axis_tdata;

    block_buffer_directory dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Shadow copy of the slot table. It is updated in the order in which the
    // directory accepts beats, so it always mirrors the state the hardware
    // will have once it has finished the beat being predicted.
    // ------------------------------------------------------------------------
    logic                      shadow_used  [bbd_pkg::SLOT_COUNT];
    logic                      shadow_dirty [bbd_pkg::SLOT_COUNT];
    logic [bbd_pkg::TAG_W-1:0] shadow_tag   [bbd_pkg::SLOT_COUNT];
    logic [bbd_pkg::AGE_W-1:0] shadow_age   [bbd_pkg::SLOT_COUNT];

    dir_request_t pending_requests[$];   // beats still to be offered
    dir_reply_t   expected_replies[$];   // predicted replies, oldest first
    dir_request_t offered_request;       // beat currently on the input bus

    // Stimulus knobs; the control sequence below changes them between phases.
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    logic sender_hold   = 1'b0;
    logic hold_request  = 1'b0;
    int  hold_left      = 0;

    int  error_count    = 0;
    int  cycle_count    = 0;
    logic [bbd_pkg::TAG_W-1:0] block_pool [POOL_SIZE];

    // Coverage tallies for the closing summary.
    int n_alloc, n_writeback, n_hit, n_miss, n_oob, n_dropped;

    // Applies one request to the shadow table and works out the reply that
    // the directory owes for it. Returns 0 for the unused command code,
    // which the directory drops without a reply.
    function automatic bit directory_apply(input dir_request_t req,
                                           output dir_reply_t reply);
        int                        pick;
        logic [bbd_pkg::AGE_W-1:0] oldest;
        logic [bbd_pkg::TAG_W-1:0] tag;
        reply = '0;
        reply.status = bbd_pkg::ST_OK;
        if (req.command == bbd_pkg::CMD_NONE)
            return 1'b0;
        if (req.block_number >= bbd_pkg::DISK_BLOCK_COUNT) begin
            // Out-of-range blocks are refused and leave the table untouched.
            reply.status = bbd_pkg::ST_OOB;
            return 1'b1;
        end
        tag  = req.block_number[bbd_pkg::TAG_W-1:0];
        pick = -1;
        if (req.command == bbd_pkg::CMD_ALLOC) begin
            for (int i = 0; i < bbd_pkg::SLOT_COUNT; i++)
                if (shadow_used[i] && shadow_age[i] != bbd_pkg::AGE_MAX)
                    shadow_age[i] = shadow_age[i] + 1'b1;
            for (int i = 0; i < bbd_pkg::SLOT_COUNT; i++)
                if (pick < 0 && !shadow_used[i])
                    pick = i;
            if (pick < 0) begin
                // Table full: evict the oldest slot, the lowest index winning ties.
                pick   = 0;
                oldest = shadow_age[0];
                for (int i = 1; i < bbd_pkg::SLOT_COUNT; i++)
                    if (shadow_age[i] > oldest) begin
                        oldest = shadow_age[i];
                        pick   = i;
                    end
                if (shadow_dirty[pick]) begin
                    reply.writeback_valid = 1'b1;
                    reply.writeback_block = shadow_tag[pick];
                end
            end
            shadow_used[pick]  = 1'b1;
            shadow_dirty[pick] = 1'b0;
            shadow_tag[pick]   = tag;
            shadow_age[pick]   = '0;
            reply.slot_index   = pick[bbd_pkg::SLOT_W-1:0];
        end else begin
            // Lookup and set-dirty act on the lowest matching used slot.
            for (int i = 0; i < bbd_pkg::SLOT_COUNT; i++)
                if (pick < 0 && shadow_used[i] && shadow_tag[i] == tag)
                    pick = i;
            if (pick < 0) begin
                reply.status = bbd_pkg::ST_MISS;
            end else begin
                if (req.command == bbd_pkg::CMD_DIRTY)
                    shadow_dirty[pick] = 1'b1;
                reply.slot_index = pick[bbd_pkg::SLOT_W-1:0];
            end
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Driver. A beat is predicted at the edge where it is accepted; the next
    // one is loaded in the same edge so that tvalid gets a single update.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        dir_reply_t reply;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (directory_apply(offered_request, reply)) begin
                    expected_replies.push_back(reply);
                    if (reply.status == bbd_pkg::ST_OOB)
                        n_oob++;
                    else if (offered_request.command == bbd_pkg::CMD_ALLOC) begin
                        n_alloc++;
                        if (reply.writeback_valid)
                            n_writeback++;
                    end else if (reply.status == bbd_pkg::ST_OK)
                        n_hit++;
                    else
                        n_miss++;
                end else begin
                    n_dropped++;
                end
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_requests.size() != 0 && !sender_hold &&
                    $urandom_range(99) >= send_idle_pct) begin
                    offered_request = pending_requests.pop_front();
                    s_axis_tvalid   <= 1'b1;
                    s_axis_tdata    <= {offered_request.block_number,
                                        offered_request.command};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so that the control sequence can
    // keep queuing beats while the directory backs up.
    always @(posedge aclk) begin
        if (hold_request)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    task automatic check_field(input string name, input int unsigned expected,
                               input int unsigned actual);
        if (expected != actual) begin
            $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor. Every accepted result beat is matched against the oldest
    // prediction; the ready decision for the next cycle is made here too.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        dir_reply_t expected;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_replies.size() == 0) begin
                    $error("result beat 0x%06h arrived with no request waiting",
                           m_axis_tdata);
                    error_count++;
                end else begin
                    expected = expected_replies.pop_front();
                    check_field("status", expected.status, m_axis_tdata[1:0]);
                    check_field("slot_index", expected.slot_index, m_axis_tdata[6:2]);
                    check_field("writeback_valid", expected.writeback_valid,
                                m_axis_tdata[7]);
                    check_field("writeback_block", expected.writeback_block,
                                m_axis_tdata[20:8]);
                end
            end
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycle_count, expected_replies.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic queue_request(input logic [bbd_pkg::CMD_W-1:0] command,
                                 input int unsigned block_number);
        dir_request_t req;
        req.command      = command;
        req.block_number = block_number[bbd_pkg::BLK_W-1:0];
        pending_requests.push_back(req);
    endtask

    // Random traffic drawn mostly from a small pool of block numbers so that
    // lookups hit, dirty slots get evicted and write-backs show up. Part of it
    // is short allocate / set-dirty / lookup runs on one block; the rest is
    // loose commands, out-of-range blocks and the unused command code.
    task automatic queue_traffic(input int count);
        int                        roll;
        int                        made;
        logic [bbd_pkg::TAG_W-1:0] blk;
        logic [bbd_pkg::CMD_W-1:0] any_cmd [3];
        any_cmd = '{bbd_pkg::CMD_ALLOC, bbd_pkg::CMD_LOOKUP, bbd_pkg::CMD_DIRTY};
        made = 0;
        while (made < count) begin
            roll = $urandom_range(99);
            blk  = block_pool[$urandom_range(POOL_SIZE - 1)];
            if (roll < 15) begin
                queue_request(bbd_pkg::CMD_ALLOC, blk);
                queue_request(bbd_pkg::CMD_DIRTY, blk);
                queue_request(bbd_pkg::CMD_LOOKUP, blk);
                made += 3;
            end else begin
                if (roll < 45)
                    queue_request(bbd_pkg::CMD_ALLOC, blk);
                else if (roll < 68)
                    queue_request(bbd_pkg::CMD_LOOKUP, blk);
                else if (roll < 90)
                    queue_request(bbd_pkg::CMD_DIRTY, blk);
                else if (roll < 96)
                    queue_request(any_cmd[$urandom_range(2)],
                                  $urandom_range(bbd_pkg::DISK_BLOCK_COUNT,
                                                 2**bbd_pkg::BLK_W - 1));
                else
                    queue_request(bbd_pkg::CMD_NONE, $urandom_range(2**bbd_pkg::BLK_W - 1));
                made++;
            end
        end
    endtask

    // Blocks until every queued beat has been offered and answered.
    task automatic wait_for_drain();
        do @(posedge aclk);
        while (pending_requests.size() != 0 || s_axis_tvalid ||
               expected_replies.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Control sequence: reset, a directed pass, then four random phases with
    // different idle mixes, a long receiver hold-off and a full sender pause.
    // ------------------------------------------------------------------------
    initial begin
        for (int i = 0; i < bbd_pkg::SLOT_COUNT; i++) begin
            shadow_used[i]  = 1'b0;
            shadow_dirty[i] = 1'b0;
            shadow_tag[i]   = '0;
            shadow_age[i]   = '0;
        end
        // The pool spans the whole legal block range, both ends included.
        block_pool[0] = '0;
        block_pool[1] = bbd_pkg::TAG_W'(bbd_pkg::DISK_BLOCK_COUNT - 1);
        for (int i = 2; i < POOL_SIZE; i++)
            block_pool[i] = bbd_pkg::TAG_W'($urandom_range(bbd_pkg::DISK_BLOCK_COUNT - 1));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed pass: misses on an empty table, both ends of the block
        // range, out-of-range blocks for every command, the unused command
        // code and a duplicate tag resolved to its lowest slot.
        queue_request(bbd_pkg::CMD_LOOKUP, 0);
        queue_request(bbd_pkg::CMD_DIRTY, 0);
        queue_request(bbd_pkg::CMD_ALLOC, 0);
        queue_request(bbd_pkg::CMD_ALLOC, bbd_pkg::DISK_BLOCK_COUNT - 1);
        queue_request(bbd_pkg::CMD_LOOKUP, bbd_pkg::DISK_BLOCK_COUNT - 1);
        queue_request(bbd_pkg::CMD_DIRTY, bbd_pkg::DISK_BLOCK_COUNT - 1);
        queue_request(bbd_pkg::CMD_LOOKUP, 0);
        queue_request(bbd_pkg::CMD_ALLOC, bbd_pkg::DISK_BLOCK_COUNT);
        queue_request(bbd_pkg::CMD_LOOKUP, 2**bbd_pkg::BLK_W - 1);
        queue_request(bbd_pkg::CMD_DIRTY, 10000);
        queue_request(bbd_pkg::CMD_NONE, 2**bbd_pkg::BLK_W - 1);
        queue_request(bbd_pkg::CMD_NONE, 0);
        queue_request(bbd_pkg::CMD_ALLOC, 0);
        queue_request(bbd_pkg::CMD_DIRTY, 0);
        queue_request(bbd_pkg::CMD_LOOKUP, 4660);
        queue_request(bbd_pkg::CMD_ALLOC, 5461);
        queue_request(bbd_pkg::CMD_ALLOC, 2730);
        queue_request(bbd_pkg::CMD_LOOKUP, 5461);
        wait_for_drain();

        // Phase one: both sides always ready.
        queue_traffic(230);
        wait_for_drain();

        // Phase two: the sender is idle most of the time.
        @(posedge aclk);
        send_idle_pct <= 70;
        queue_traffic(230);
        wait_for_drain();

        // Phase three: the receiver stalls most of the time and starts with a
        // long hold-off while the sender keeps offering, so the input backs up.
        @(posedge aclk);
        send_idle_pct  <= 0;
        recv_stall_pct <= 70;
        hold_request   <= 1'b1;
        queue_traffic(230);
        @(posedge aclk);
        hold_request <= 1'b0;
        wait_for_drain();

        // Phase four: light idling on both sides, with a pause in the middle
        // during which the sender waits for every outstanding reply.
        @(posedge aclk);
        send_idle_pct  <= 18;
        recv_stall_pct <= 18;
        queue_traffic(240);
        repeat (1500) @(posedge aclk);
        sender_hold <= 1'b1;
        do @(posedge aclk);
        while (s_axis_tvalid || expected_replies.size() != 0);
        repeat (20) @(posedge aclk);
        sender_hold <= 1'b0;
        wait_for_drain();

        // Give a dropped command or a stray result time to show itself.
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_replies.size() != 0) begin
            $error("%0d predicted replies never arrived", expected_replies.size());
            error_count++;
        end

        $display("Covered %0d allocations (%0d write-backs), %0d hits, %0d misses,",
                 n_alloc, n_writeback, n_hit, n_miss);
        $display("%0d out-of-range and %0d dropped beats under four idle mixes.",
                 n_oob, n_dropped);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sim.f
src/bbd_pkg.sv
src/block_buffer_directory.sv
src/bbd_checker.sv
test/tb_top.sv
